[hw/rtl/icp_pkg.sv]
`timescale 1ns / 1ps
// icp_pkg: shared types, widths, constants and the arctangent table for the
// complementary pitch estimator; no dependencies

package icp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_TABLE_LEN    = 24;

    localparam int RAW_W    = 16;   // raw samples, offsets, angles at the ports
    localparam int SAMPLE_W = 17;   // offset corrected samples
    localparam int XY_W     = 32;   // cordic vector components
    localparam int ANG_W    = 34;   // cordic angle accumulator, q2.30
    localparam int GW_W     = 50;   // gyro path times weight
    localparam int AP_W     = 34;   // accel pitch times complement weight
    localparam int TOT_W    = 51;   // blended sum, q45
    localparam int OUT_W    = 16;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30   = 34'sd1686629713;
    localparam logic signed [21:0]      GYRO_GAIN_Q40 = 22'sd1199399;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PERIOD_US = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ACCEL_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ACCEL_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_GYRO_X  = 3'd4;

    localparam logic [15:0] BLEND_WEIGHT_RST   = 16'd64225;
    localparam logic [15:0] LOOP_PERIOD_US_RST = 16'd1000;

    typedef struct packed {
        logic                    valid;
        logic                    zero;   // both accel components were zero
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } cordic_vec_t;

    // atan(2^-i) truncated to q2.30
    function automatic logic signed [ANG_W-1:0] atan_q30(input int idx);
        logic signed [ANG_W-1:0] a;
        case (idx)
            0:       a = 34'sd843314856;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043836;
            3:       a = 34'sd133525158;
            4:       a = 34'sd67021686;
            5:       a = 34'sd33543515;
            6:       a = 34'sd16775850;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194282;
            9:       a = 34'sd2097149;
            10:      a = 34'sd1048575;
            11:      a = 34'sd524287;
            12:      a = 34'sd262143;
            13:      a = 34'sd131071;
            14:      a = 34'sd65535;
            15:      a = 34'sd32767;
            16:      a = 34'sd16383;
            17:      a = 34'sd8191;
            18:      a = 34'sd4095;
            19:      a = 34'sd2047;
            20:      a = 34'sd1023;
            21:      a = 34'sd511;
            22:      a = 34'sd255;
            23:      a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/imu_complementary_pitch.sv]
`timescale 1ns / 1ps
// imu_complementary_pitch: top level of the complementary-filter pitch estimator
// depends on icp_pkg, icp_cordic_cell, icp_gyro_path and icp_out_buf
//
//  channel   direction  handshake            payload
//  s_        in         s_tvalid/s_tready    raw accel y, accel z, gyro x, prior angle
//  m_        out        m_tvalid/m_tready    pitch angle, q2.13 radians
//  cfg_      in         cfg_valid/cfg_ready  register index and 16-bit value
//
// one transaction is accepted per cycle unless the output queue is full;
// each one returns one result, passing in order through the input register,
// pre-rotation, one cordic cell per stage, blend register and output queue
// reset clears the valid bits, the output queue and the registers to defaults
// the whole pipeline holds only while both output queue entries are full

module imu_complementary_pitch #(
    parameter int CORDIC_STAGES = icp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // raw_accel_y [15:0], raw_accel_z [31:16], raw_gyro_x [47:32],
    // prior_angle [63:48]
    input  logic [63:0]                      s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pitch_angle [15:0]
    output logic [15:0]                      m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [icp_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  logic [15:0]                      cfg_wdata
);
    import icp_pkg::*;

    // gyro path already has four registers after the input stage
    localparam int GYRO_DELAY = CORDIC_STAGES - 3;

    // configuration registers
    logic [15:0] blend_weight_reg;
    logic [15:0] loop_period_us_reg;
    logic [15:0] offset_accel_y_reg;
    logic [15:0] offset_accel_z_reg;
    logic [15:0] offset_gyro_x_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_weight_reg   <= BLEND_WEIGHT_RST;
            loop_period_us_reg <= LOOP_PERIOD_US_RST;
            offset_accel_y_reg <= '0;
            offset_accel_z_reg <= '0;
            offset_gyro_x_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_BLEND_WEIGHT:   blend_weight_reg   <= cfg_wdata;
                CFG_LOOP_PERIOD_US: loop_period_us_reg <= cfg_wdata;
                CFG_OFFSET_ACCEL_Y: offset_accel_y_reg <= cfg_wdata;
                CFG_OFFSET_ACCEL_Z: offset_accel_z_reg <= cfg_wdata;
                CFG_OFFSET_GYRO_X:  offset_gyro_x_reg  <= cfg_wdata;
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    // pipeline advance: everything moves together unless the queue is full
    logic en;
    logic out_full;

    assign en       = !out_full;
    assign s_tready = en;

    // input stage: offset correction, exact 17-bit differences
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] ay_reg;
    logic signed [SAMPLE_W-1:0] az_reg;
    logic signed [SAMPLE_W-1:0] gx_reg;
    logic signed [RAW_W-1:0]    prior_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ay_reg    <= SAMPLE_W'(signed'(s_tdata[15:0]))
                       - SAMPLE_W'(signed'(offset_accel_y_reg));
            az_reg    <= SAMPLE_W'(signed'(s_tdata[31:16]))
                       - SAMPLE_W'(signed'(offset_accel_z_reg));
            gx_reg    <= SAMPLE_W'(signed'(s_tdata[47:32]))
                       - SAMPLE_W'(signed'(offset_gyro_x_reg));
            prior_reg <= signed'(s_tdata[63:48]);
        end
    end

    // pre-rotation into the right half plane; x is accel y, y is accel z
    cordic_vec_t chain [CORDIC_STAGES+1];
    cordic_vec_t pre_next;

    always_comb begin
        logic signed [XY_W-1:0] x0;
        logic signed [XY_W-1:0] y0;
        x0 = XY_W'(ay_reg) <<< 12;
        y0 = XY_W'(az_reg) <<< 12;
        pre_next.valid = in_valid_reg;
        pre_next.zero  = (ay_reg == '0) && (az_reg == '0);
        pre_next.x     = x0;
        pre_next.y     = y0;
        pre_next.z     = '0;
        if (x0[XY_W-1]) begin
            if (!y0[XY_W-1]) begin
                pre_next.x = y0;
                pre_next.y = -x0;
                pre_next.z = HALF_PI_Q30;
            end else begin
                pre_next.x = -y0;
                pre_next.y = x0;
                pre_next.z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain[0].valid <= 1'b0;
        end else if (en) begin
            chain[0] <= pre_next;
        end
    end

    // row of micro-rotation cells, one stage each
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
        icp_cordic_cell #(
            .SHIFT (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vec_in  (chain[k]),
            .vec_out (chain[k+1])
        );
    end

    // gyro path runs beside the cells and lines up with the last one
    logic signed [GW_W-1:0] gw_aligned;

    icp_gyro_path #(
        .DELAY (GYRO_DELAY)
    ) u_gyro (
        .aclk   (aclk),
        .en     (en),
        .gx     (gx_reg),
        .prior  (prior_reg),
        .dt     (loop_period_us_reg),
        .weight (blend_weight_reg),
        .gw     (gw_aligned)
    );

    // blend stage: round the cordic angle to q2.13, weight it by 1 - tau
    logic                    blend_valid_reg;
    logic signed [AP_W-1:0]  ap_reg;
    logic signed [GW_W-1:0]  gw_blend_reg;
    logic signed [AP_W-1:0]  ap_next;

    always_comb begin
        logic signed [ANG_W-1:0] z_rnd;
        logic signed [ANG_W-1:0] z_shift;
        logic signed [RAW_W-1:0] accel;
        logic        [16:0]      w_comp;
        z_rnd   = chain[CORDIC_STAGES].z + ANG_W'(signed'(18'sd65536));
        z_shift = z_rnd >>> 17;
        // both accel components zero gives a pitch of zero
        accel   = chain[CORDIC_STAGES].zero ? '0 : z_shift[RAW_W-1:0];
        w_comp  = 17'd65536 - {1'b0, blend_weight_reg};
        ap_next = AP_W'(accel * $signed({1'b0, w_comp}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_valid_reg <= 1'b0;
        end else if (en) begin
            blend_valid_reg <= chain[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ap_reg       <= ap_next;
            gw_blend_reg <= gw_aligned;
        end
    end

    // sum, negate, round half up, saturate
    logic [OUT_W-1:0] pitch;

    always_comb begin
        logic signed [TOT_W-1:0] total;
        logic signed [TOT_W:0]   neg;
        logic signed [TOT_W:0]   r;
        total = TOT_W'(gw_blend_reg) + (TOT_W'(ap_reg) <<< 16);
        neg   = (TOT_W+1)'(signed'(33'sd2147483648)) - (TOT_W+1)'(total);
        r     = neg >>> 32;
        if (r > (TOT_W+1)'(signed'(17'sd32767))) begin
            pitch = 16'h7fff;
        end else if (r < (TOT_W+1)'(signed'(17'sh18000))) begin
            pitch = 16'h8000;
        end else begin
            pitch = r[OUT_W-1:0];
        end
    end

    icp_out_buf #(
        .W (OUT_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (en & blend_valid_reg),
        .din      (pitch),
        .full     (out_full),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

[hw/rtl/icp_cordic_cell.sv]
`timescale 1ns / 1ps
// icp_cordic_cell: one registered vectoring cordic micro-rotation
// depends on icp_pkg

module icp_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  icp_pkg::cordic_vec_t vec_in,
    output icp_pkg::cordic_vec_t vec_out
);
    import icp_pkg::*;

    cordic_vec_t vec_reg;
    cordic_vec_t vec_next;

    always_comb begin
        logic signed [XY_W-1:0]  x_in;
        logic signed [XY_W-1:0]  y_in;
        logic signed [XY_W-1:0]  dx;
        logic signed [XY_W-1:0]  dy;
        logic signed [ANG_W-1:0] z_in;
        logic signed [ANG_W-1:0] ang;
        x_in = vec_in.x;
        y_in = vec_in.y;
        z_in = vec_in.z;
        dx   = y_in >>> SHIFT;
        dy   = x_in >>> SHIFT;
        ang  = atan_q30(SHIFT);
        vec_next = vec_in;
        // rotate toward the x axis, sign of y picks the direction
        if (!y_in[XY_W-1]) begin
            vec_next.x = x_in + dx;
            vec_next.y = y_in - dy;
            vec_next.z = z_in + ang;
        end else begin
            vec_next.x = x_in - dx;
            vec_next.y = y_in + dy;
            vec_next.z = z_in - ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg.valid <= 1'b0;
        end else if (en) begin
            vec_reg <= vec_next;
        end
    end

    assign vec_out = vec_reg;

endmodule

[hw/rtl/icp_gyro_path.sv]
`timescale 1ns / 1ps
// icp_gyro_path: gyro increment, prior angle sum, weight product and an
// alignment delay line; depends on icp_pkg

module icp_gyro_path #(
    parameter int DELAY = 13
) (
    input  logic                                    aclk,
    input  logic                                    en,
    input  logic signed [icp_pkg::SAMPLE_W-1:0]     gx,
    input  logic signed [icp_pkg::RAW_W-1:0]        prior,
    input  logic        [icp_pkg::RAW_W-1:0]        dt,
    input  logic        [icp_pkg::RAW_W-1:0]        weight,
    output logic signed [icp_pkg::GW_W-1:0]         gw
);
    import icp_pkg::*;

    localparam int M1_W  = SAMPLE_W + RAW_W + 1;
    localparam int M2_W  = M1_W + 22;
    localparam int INC_W = 30;
    localparam int GP_W  = 33;

    logic signed [M1_W-1:0]  m1_reg;
    logic signed [M2_W-1:0]  m2_reg;
    logic signed [RAW_W-1:0] prior_d1_reg;
    logic signed [RAW_W-1:0] prior_d2_reg;
    logic signed [GP_W-1:0]  gp_reg;
    logic signed [GW_W-1:0]  gw_reg;
    logic signed [GW_W-1:0]  dly_reg [DELAY];

    logic signed [M2_W-1:0]  m2_rnd;
    logic signed [INC_W-1:0] inc;

    // round the increment to q2.29 scale
    assign m2_rnd = m2_reg + M2_W'(signed'(25'sd8388608));
    assign inc    = INC_W'(m2_rnd >>> 24);

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg       <= M1_W'(gx * $signed({1'b0, dt}));
            m2_reg       <= M2_W'(m1_reg * GYRO_GAIN_Q40);
            // prior angle walks beside the two multiplier stages
            prior_d1_reg <= prior;
            prior_d2_reg <= prior_d1_reg;
            gp_reg       <= (GP_W'(prior_d2_reg) <<< 16) + GP_W'(inc);
            gw_reg       <= GW_W'(gp_reg * $signed({1'b0, weight}));
            dly_reg[0]   <= gw_reg;
            for (int i = 1; i < DELAY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign gw = dly_reg[DELAY-1];

endmodule

[hw/rtl/icp_out_buf.sv]
`timescale 1ns / 1ps
// icp_out_buf: two-entry output register queue for the result stream
// depends on icp_pkg for nothing but the import convention

module icp_out_buf #(
    parameter int W = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [W-1:0] m_tdata
);
    import icp_pkg::*;

    logic [1:0]   cnt_reg;
    logic [W-1:0] e0_reg;
    logic [W-1:0] e1_reg;
    logic         pop;

    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign full     = (cnt_reg == 2'd2);
    assign m_tdata  = e0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    e0_reg <= din;
                end else begin
                    e0_reg <= e1_reg;
                    e1_reg <= din;
                end
            end
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    e0_reg <= din;
                end else begin
                    e1_reg <= din;
                end
            end
            2'b01: begin
                e0_reg <= e1_reg;
            end
            default: begin
            end
        endcase
    end

endmodule
